// ----- sv/luhn_card_type_check_defines.svh -----
// Assertion macros for the Luhn card check block.
// LCC_ASSERT is gated by reset; LCC_ASSERT_ALWAYS also checks through reset.
`ifndef LUHN_CARD_TYPE_CHECK_DEFINES_SVH
`define LUHN_CARD_TYPE_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
`define LCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define LCC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define LCC_ASSERT(lbl, clk, rst_n, prop)
`define LCC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- sv/lcc_pkg.sv -----
package lcc_pkg;

    localparam int CARD_W      = 63;            // card number width
    localparam int DIGITS      = 19;            // max decimal digits of a 63-bit value
    localparam int BCD_W       = DIGITS * 4;
    localparam int CNT_W       = 6;             // holds CARD_W - 1
    localparam int DIG_IDX_W   = 5;             // holds DIGITS
    localparam int KIND_W      = 2;

    localparam logic [CNT_W-1:0] LAST_BIT   = CNT_W'(CARD_W - 1);
    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(DIGITS - 1);

    // issuer rule constants
    localparam logic [3:0] D_AMEX_HI = 4'd3;
    localparam logic [3:0] D_AMEX_LO_A = 4'd4;
    localparam logic [3:0] D_AMEX_LO_B = 4'd7;
    localparam logic [3:0] D_MC_HI   = 4'd5;
    localparam logic [3:0] D_MC_LO_MIN = 4'd1;
    localparam logic [3:0] D_MC_LO_MAX = 4'd5;
    localparam logic [3:0] D_VISA    = 4'd4;
    localparam logic [DIG_IDX_W-1:0] LEN_AMEX   = DIG_IDX_W'(15);
    localparam logic [DIG_IDX_W-1:0] LEN_16     = DIG_IDX_W'(16);
    localparam logic [DIG_IDX_W-1:0] LEN_13     = DIG_IDX_W'(13);

    typedef enum logic [KIND_W-1:0] {
        KIND_INVALID    = 2'd0,
        KIND_AMEX       = 2'd1,
        KIND_MASTERCARD = 2'd2,
        KIND_VISA       = 2'd3
    } t_kind;

    // controller -> datapath commands
    typedef struct packed {
        logic                 load;     // capture new card number
        logic                 dabble;   // one double-dabble shift
        logic                 scan;     // consume one BCD digit
        logic                 publish;  // load result registers
        logic [DIG_IDX_W-1:0] idx;      // digit index during scan
    } t_cmd;

endpackage

// ----- sv/lcc_ctrl.sv -----
`include "luhn_card_type_check_defines.svh"

module lcc_ctrl
    import lcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DABBLE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.idx     = r_cnt[DIG_IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DABBLE;
                end
            end
            S_DABBLE: begin
                o_cmd.dabble = 1'b1;
                if (r_cnt == LAST_BIT) begin
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_cnt == LAST_DIGIT) begin
                    n_cnt   = '0;
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `LCC_ASSERT(a_publish_free, i_clk, i_rst_n, o_cmd.publish |-> (!r_out_valid || i_out_ready))
    `LCC_ASSERT(a_accept_start, i_clk, i_rst_n, accept |=> (r_state == S_DABBLE && r_cnt == '0))
    `LCC_ASSERT(a_scan_range, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_cnt <= LAST_DIGIT))
    `LCC_ASSERT(a_valid_from_finish, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_FINISH))
    `LCC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid))

endmodule

// ----- sv/lcc_dp.sv -----
module lcc_dp
    import lcc_pkg::*;
(
    input  logic                 i_clk,
    input  t_cmd                 i_cmd,
    input  logic [CARD_W-1:0]    i_card_number,
    output logic [KIND_W-1:0]    o_card_kind,
    output logic                 o_luhn_ok,
    output logic [DIG_IDX_W-1:0] o_digit_count
);

    logic [CARD_W-1:0]    r_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic [3:0]           r_sum;       // Luhn sum mod 10
    logic [DIG_IDX_W-1:0] r_ndig;
    logic [3:0]           r_lead_hi;
    logic [3:0]           r_lead_lo;
    logic [3:0]           r_prev;
    logic [KIND_W-1:0]    r_kind;
    logic                 r_ok;
    logic [DIG_IDX_W-1:0] r_count;

    logic [BCD_W-1:0]     bcd_adj;
    logic [3:0]           dig;
    logic [4:0]           dig2;
    logic [4:0]           luhn_d;
    logic [4:0]           sum5;
    logic [3:0]           n_sum;
    t_kind                kind;
    logic                 ok;

    // add-3 correction on every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    // one Luhn digit per scan cycle, odd positions doubled
    always_comb begin
        dig  = r_bcd[3:0];
        dig2 = {dig, 1'b0};
        if (i_cmd.idx[0]) begin
            luhn_d = (dig2 > 5'd9) ? dig2 - 5'd9 : dig2;
        end else begin
            luhn_d = {1'b0, dig};
        end
        sum5  = {1'b0, r_sum} + luhn_d;
        n_sum = (sum5 >= 5'd10) ? 4'(sum5 - 5'd10) : sum5[3:0];
    end

    always_comb begin
        ok   = (r_sum == 4'd0);
        kind = KIND_INVALID;
        if (ok) begin
            if (r_lead_hi == D_AMEX_HI && (r_lead_lo == D_AMEX_LO_A ||
                r_lead_lo == D_AMEX_LO_B) && r_ndig == LEN_AMEX) begin
                kind = KIND_AMEX;
            end else if (r_lead_hi == D_MC_HI && r_lead_lo >= D_MC_LO_MIN &&
                         r_lead_lo <= D_MC_LO_MAX && r_ndig == LEN_16) begin
                kind = KIND_MASTERCARD;
            end else if (r_lead_hi == D_VISA &&
                         (r_ndig == LEN_13 || r_ndig == LEN_16)) begin
                kind = KIND_VISA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin     <= i_card_number;
            r_bcd     <= '0;
            r_sum     <= '0;
            r_ndig    <= '0;
            r_lead_hi <= '0;
            r_lead_lo <= '0;
            r_prev    <= '0;
        end else if (i_cmd.dabble) begin
            r_bcd <= {bcd_adj[BCD_W-2:0], r_bin[CARD_W-1]};
            r_bin <= {r_bin[CARD_W-2:0], 1'b0};
        end else if (i_cmd.scan) begin
            r_bcd  <= {4'd0, r_bcd[BCD_W-1:4]};
            r_sum  <= n_sum;
            r_prev <= dig;
            if (dig != 4'd0) begin
                r_ndig    <= i_cmd.idx + 1'b1;
                r_lead_hi <= dig;
                r_lead_lo <= r_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_kind  <= kind;
            r_ok    <= ok;
            r_count <= r_ndig;
        end
    end

    assign o_card_kind   = r_kind;
    assign o_luhn_ok     = r_ok;
    assign o_digit_count = r_count;

endmodule

// ----- sv/luhn_card_type_check.sv -----
// Flow: input accept, 63 double-dabble shifts, the 19-digit scan, one result load,
//   after which o_out_valid rises. A new item is taken only once the previous one is published;
//   the bit-serial binary-to-BCD loop and the one-digit-a-cycle Luhn scan set the pace.
//   A waiting result stalls only the finish step.
// Reset: i_rst_n synchronous, active low; clears the controller and o_out_valid.
module luhn_card_type_check
    import lcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CARD_W-1:0]    i_card_number,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KIND_W-1:0]    o_card_kind,
    output logic                 o_luhn_ok,
    output logic [DIG_IDX_W-1:0] o_digit_count
);

    // Flow per item:
    //   load     - card number captured, BCD register cleared
    //   dabble   - 63 shift-and-add-3 steps turn the binary into 19 BCD digits
    //   scan     - digits leave LSD first; odd positions doubled (minus 9 over 9),
    //              sum kept mod 10; the last nonzero digit fixes length and leads
    //   finish   - issuer decided, result loaded into the output register as
    //              soon as the previous result has been taken
    // The output register is separate from the working registers, so a new item
    // is accepted while the last result still waits downstream.

    t_cmd cmd;

    lcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    lcc_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_card_number (i_card_number),
        .o_card_kind   (o_card_kind),
        .o_luhn_ok     (o_luhn_ok),
        .o_digit_count (o_digit_count)
    );

endmodule
